FILE: hdl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg: shared types and constants for the fraction arithmetic reducer
// Command codes, status codes, payload structs and controller command bundle.
// ----------------------------------------------------------------------------
package far_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int RES_W         = 64;
    localparam int CNT_W         = $clog2(RES_W + 1);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] a_numerator;
        logic signed [31:0] a_denominator;
        logic signed [31:0] b_numerator;
        logic signed [31:0] b_denominator;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] result_numerator;
        logic signed [63:0] result_denominator;
        logic [1:0]         status;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture inputs, check errors, form operands
        logic mul;       // products registered
        logic combine;   // form raw n, d
        logic div_start; // start a divide with current dividend/divisor
        logic div_step;  // one restoring divide step
        logic euc_next;  // x <= y, y <= remainder; seeds x = |n|, y = |d| when both are zero
        logic red_n;     // start |n| / g
        logic red_d;     // take quotient of n, start |d| / g
        logic fin;       // take quotient of d, build result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;       // error found at load
        logic n_zero;    // raw numerator zero
        logic y_zero;    // euclid divisor is zero
        logic div_done;  // divide finished
    } t_dp_sts;

endpackage

FILE: hdl/far_datapath.sv
// ----------------------------------------------------------------------------
// far_datapath: operand products, Euclid GCD and reduction
// One shared restoring divider (one bit a cycle) does the Euclid remainders
// and the final two quotients.
// ----------------------------------------------------------------------------
module far_datapath (
    input  logic               i_clk,
    input  far_pkg::t_in_word  i_in,
    input  far_pkg::t_dp_cmd   i_cmd,
    output far_pkg::t_dp_sts   o_sts,
    output far_pkg::t_out_word o_out
);
    localparam int W  = far_pkg::OPERAND_WIDTH;
    localparam int RW = far_pkg::RES_W;

    logic [1:0]           r_cmd;
    logic signed [W:0]    r_an, r_ad, r_bn, r_bd;
    logic                 r_err;
    logic [1:0]           r_err_code;
    logic signed [RW-1:0] r_p0, r_p1, r_p2;
    logic                 r_same_den;
    logic [RW-1:0]        r_n, r_d, r_x, r_y;
    logic [RW-1:0]        r_q, r_rem, r_dvs, r_qn;
    logic [far_pkg::CNT_W-1:0] r_cnt;
    far_pkg::t_out_word   r_out;

    function automatic logic signed [W:0] sx(input logic [31:0] v);
        return (W+1)'($signed(v[W-1:0]));
    endfunction

    function automatic logic [RW-1:0] mag(input logic [RW-1:0] v);
        return v[RW-1] ? (~v + RW'(1)) : v;
    endfunction

    // 33 x 33 signed product; magnitude never exceeds 2^62
    function automatic logic signed [RW-1:0] smul(input logic signed [W:0] a,
                                                  input logic signed [W:0] b);
        logic signed [2*W+1:0] p;
        p = a * b;
        return p[RW-1:0];
    endfunction

    logic signed [W:0]    s_an, s_ad, s_bn, s_bd;
    logic                 s_err1, s_err2;
    logic [RW:0]          s_trial;
    logic [RW-1:0]        s_shift;

    always_comb begin
        s_an   = sx(i_in.a_numerator);
        s_ad   = sx(i_in.a_denominator);
        s_bn   = sx(i_in.b_numerator);
        s_bd   = sx(i_in.b_denominator);
        s_err1 = (s_ad == '0) || (s_bd == '0);
        s_err2 = (i_in.command == far_pkg::CMD_DIV) && (s_bn == '0);
        s_shift = {r_rem[RW-2:0], r_q[RW-1]};
        s_trial = {1'b0, s_shift} - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_in.command;
            r_an       <= s_an;
            r_ad       <= s_ad;
            r_bn       <= (i_in.command == far_pkg::CMD_SUB) ? -s_bn : s_bn;
            r_bd       <= s_bd;
            r_err      <= s_err1 || s_err2;
            r_err_code <= s_err1 ? far_pkg::ST_ZERO_DEN : far_pkg::ST_DIV_ZERO;
        end
        // operands held as 33-bit signed (negated bn may be 2^31)
        if (i_cmd.mul) begin
            r_same_den <= (r_ad == r_bd);
            case (r_cmd)
                far_pkg::CMD_MUL: begin
                    r_p0 <= smul(r_an, r_bn);
                    r_p2 <= smul(r_ad, r_bd);
                end
                far_pkg::CMD_DIV: begin
                    r_p0 <= smul(r_an, r_bd);
                    r_p2 <= smul(r_ad, r_bn);
                end
                default: begin
                    r_p0 <= smul(r_an, r_bd);
                    r_p1 <= smul(r_bn, r_ad);
                    r_p2 <= smul(r_ad, r_bd);
                end
            endcase
        end
        if (i_cmd.combine) begin
            if (r_cmd == far_pkg::CMD_ADD || r_cmd == far_pkg::CMD_SUB) begin
                if (r_same_den) begin
                    r_n <= RW'(r_an) + RW'(r_bn);
                    r_d <= RW'(r_ad);
                end else begin
                    r_n <= r_p0 + r_p1;
                    r_d <= r_p2;
                end
            end else begin
                r_n <= r_p0;
                r_d <= r_p2;
            end
        end
        if (i_cmd.div_start) begin
            // reduce divides use |n|, |d| over the gcd in x
            r_q   <= i_cmd.red_n ? mag(r_n) : (i_cmd.red_d ? mag(r_d) : r_x);
            r_dvs <= (i_cmd.red_n || i_cmd.red_d) ? r_x : r_y;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!s_trial[RW]) begin
                r_rem <= s_trial[RW-1:0];
                r_q   <= {r_q[RW-2:0], 1'b1};
            end else begin
                r_rem <= s_shift;
                r_q   <= {r_q[RW-2:0], 1'b0};
            end
            r_cnt <= r_cnt + far_pkg::CNT_W'(1);
        end
        if (i_cmd.combine) begin
            r_x <= '0;
            r_y <= '0;
        end
        if (i_cmd.euc_next) begin
            if (r_x == '0 && r_y == '0) begin
                // seed: x = |n|, y = |d|
                r_x <= mag(r_n);
                r_y <= mag(r_d);
            end else begin
                r_x <= r_y;
                r_y <= r_rem;
            end
        end
        if (i_cmd.red_d) r_qn <= r_q;
        if (i_cmd.fin) begin
            if (r_err) begin
                r_out.result_numerator   <= '0;
                r_out.result_denominator <= '0;
                r_out.status             <= r_err_code;
            end else if (r_n == '0) begin
                r_out.result_numerator   <= '0;
                r_out.result_denominator <= RW'(1);
                r_out.status             <= far_pkg::ST_OK;
            end else begin
                r_out.result_numerator   <= r_n[RW-1] ? -r_qn : r_qn;
                r_out.result_denominator <= r_d[RW-1] ? -r_q : r_q;
                r_out.status             <= far_pkg::ST_OK;
            end
        end
    end

    always_comb begin
        o_sts.err      = r_err;
        o_sts.n_zero   = (r_n == '0);
        o_sts.y_zero   = (r_y == '0) && (r_x != '0);
        o_sts.div_done = (r_cnt == far_pkg::CNT_W'(RW));
        o_out          = r_out;
    end

endmodule

FILE: hdl/far_ctrl.sv
// ----------------------------------------------------------------------------
// far_ctrl: sequencer for the fraction reducer
// Steps load, multiply, combine, the Euclid loop and two reduce divides.
// ----------------------------------------------------------------------------
module far_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  far_pkg::t_dp_sts i_sts,
    output far_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_COMB  = 10'b0000000100,
        S_SEED  = 10'b0000001000,
        S_TEST  = 10'b0000010000,
        S_EDIV  = 10'b0000100000,
        S_RN    = 10'b0001000000,
        S_RD    = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.mul = 1'b1;
                n_state   = i_sts.err ? S_FIN : S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state       = S_SEED;
            end
            S_SEED: begin
                if (i_sts.n_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.euc_next = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.y_zero) begin
                    // gcd in x: start |n| / g
                    o_cmd.red_n     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_RN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_EDIV;
                end
            end
            S_EDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.euc_next = 1'b1;
                    n_state        = S_TEST;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_RN: begin
                if (i_sts.div_done) begin
                    o_cmd.red_d     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_RD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_RD: begin
                if (i_sts.div_done) n_state = S_FIN;
                else o_cmd.div_step = 1'b1;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> o_busy) else $error("start lost");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && i_sts.err) |=> r_state == S_FIN)
        else $error("error not short-cut");
endmodule

FILE: hdl/fraction_arithmetic_reducer.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_reducer: add/sub/mul/div of two fractions, Euclid reduced
// An error goes from the check straight to the result; a zero numerator
// skips Euclid. Otherwise Euclid remainder steps and two reduce divides
// follow, each divide 64 one-bit steps. One word at a time: busy stays high
// through the result cycle, so the next word is taken in the cycle after o_done.
// Synchronous active-low reset returns the sequencer to idle; results never stall.
// ----------------------------------------------------------------------------
module fraction_arithmetic_reducer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  far_pkg::t_in_word  i_in,
    output logic               busy,
    output logic               o_done,
    output far_pkg::t_out_word o_out
);
    far_pkg::t_dp_cmd s_cmd;
    far_pkg::t_dp_sts s_sts;

    far_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    far_datapath u_dp (
        .i_clk (i_clk),
        .i_in  (i_in),
        .i_cmd (s_cmd),
        .o_sts (s_sts),
        .o_out (o_out)
    );
endmodule
